// ===== src/alis_pkg.sv =====
// ----------------------------------------------------------------------------
// alis_pkg
// Shared types and constants for the array list insert/shift unit.
// ----------------------------------------------------------------------------
package alis_pkg;

  // Store geometry
  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned ReqW = 2;
  localparam int unsigned IdxW = 10;
  localparam int unsigned ValW = 31;

  // Width that holds both an index and the fill count for compares
  localparam int unsigned CmpW = (CntW > IdxW) ? CntW : IdxW;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    REQ_READ   = 2'd0,
    REQ_WRITE  = 2'd1,
    REQ_INSERT = 2'd2
  } req_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_FINAL
  } alis_state_e;

  // Memory access issued by the sequencer each cycle
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ValW-1:0]  wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

// ===== src/alis_ram.sv =====
// ----------------------------------------------------------------------------
// alis_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module alis_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/alis_ctrl.sv =====
// ----------------------------------------------------------------------------
// alis_ctrl
// Request sequencer: decodes one word, keeps the fill count, and walks the
// store downward one read-write per cycle for an insert with shift.
// ----------------------------------------------------------------------------
module alis_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic [alis_pkg::ReqW-1:0]    req_type_i,
  input  logic [alis_pkg::IdxW-1:0]    slot_index_i,
  input  logic [alis_pkg::ValW-1:0]    new_value_i,
  input  logic [alis_pkg::ValW-1:0]    rdata_i,
  output alis_pkg::mem_req_t           mem_req_o,
  output logic                         busy,
  output logic                         valid_o,
  output logic [alis_pkg::ValW-1:0]    read_value_o
);

  alis_pkg::alis_state_e state_q, state_d;

  logic [alis_pkg::CntW-1:0] fill_q, fill_d;
  logic [alis_pkg::CntW-1:0] ptr_q, ptr_d;
  logic [alis_pkg::IdxW-1:0] idx_q, idx_d;
  logic [alis_pkg::ValW-1:0] val_q, val_d;
  logic                      zero_q, zero_d;

  logic                      accept;
  logic                      used;
  logic                      full;
  logic                      val_nz;
  logic                      needs_shift;
  logic                      shift_more;
  logic [alis_pkg::CntW-1:0] last_c;
  logic [alis_pkg::CmpW-1:0] idx_w;
  logic [alis_pkg::CntW-1:0] ptr_m1;

  // request decode
  assign accept      = start && (state_q == alis_pkg::ST_IDLE);
  assign idx_w       = alis_pkg::CmpW'(slot_index_i);
  assign used        = idx_w < alis_pkg::CmpW'(fill_q);
  assign full        = fill_q == alis_pkg::CntW'(alis_pkg::DEPTH);
  assign val_nz      = new_value_i != '0;
  // highest slot holding data after the shift
  assign last_c      = full ? alis_pkg::CntW'(alis_pkg::DEPTH - 1) : fill_q;
  assign needs_shift = alis_pkg::CmpW'(last_c) > idx_w;
  assign ptr_m1      = ptr_q - alis_pkg::CntW'(1);
  assign shift_more  = alis_pkg::CmpW'(ptr_m1) > alis_pkg::CmpW'(idx_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      alis_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_type_i)
            alis_pkg::REQ_READ: begin
              state_d = alis_pkg::ST_READ;
            end
            alis_pkg::REQ_WRITE: begin
              if (val_nz && !used) state_d = alis_pkg::ST_READ;
            end
            alis_pkg::REQ_INSERT: begin
              if (val_nz && used && needs_shift) state_d = alis_pkg::ST_SHIFT;
            end
            default: state_d = alis_pkg::ST_IDLE;
          endcase
        end
      end
      alis_pkg::ST_READ:  state_d = alis_pkg::ST_IDLE;
      alis_pkg::ST_SHIFT: begin
        if (!shift_more) state_d = alis_pkg::ST_FINAL;
      end
      alis_pkg::ST_FINAL: state_d = alis_pkg::ST_IDLE;
      default:            state_d = alis_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory access
  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = alis_pkg::AddrW'(slot_index_i);
    mem_req_o.wdata = new_value_i;
    mem_req_o.raddr = alis_pkg::AddrW'(slot_index_i);
    busy            = 1'b1;
    valid_o         = 1'b0;
    read_value_o    = zero_q ? '0 : rdata_i;
    case (state_q)
      alis_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept && val_nz) begin
          case (req_type_i)
            alis_pkg::REQ_WRITE: begin
              mem_req_o.we = used;
            end
            alis_pkg::REQ_INSERT: begin
              if (!used) begin
                // append after the last occupied slot
                mem_req_o.we    = !full;
                mem_req_o.waddr = alis_pkg::AddrW'(fill_q);
              end else if (needs_shift) begin
                mem_req_o.raddr = alis_pkg::AddrW'(last_c - alis_pkg::CntW'(1));
              end else begin
                // full store, insert at the last slot: drop and replace
                mem_req_o.we = 1'b1;
              end
            end
            default: mem_req_o.we = 1'b0;
          endcase
        end
      end
      alis_pkg::ST_READ: begin
        valid_o = 1'b1;
      end
      alis_pkg::ST_SHIFT: begin
        // move slot ptr-1 up into ptr, fetch the next one down
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = alis_pkg::AddrW'(ptr_q);
        mem_req_o.wdata = rdata_i;
        mem_req_o.raddr = alis_pkg::AddrW'(ptr_q - alis_pkg::CntW'(2));
      end
      alis_pkg::ST_FINAL: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = alis_pkg::AddrW'(idx_q);
        mem_req_o.wdata = val_q;
        mem_req_o.raddr = alis_pkg::AddrW'(ptr_q);
      end
      default: busy = 1'b1;
    endcase
  end

  // datapath registers
  always_comb begin
    fill_d = fill_q;
    ptr_d  = ptr_q;
    idx_d  = idx_q;
    val_d  = val_q;
    zero_d = zero_q;
    if (accept) begin
      idx_d = slot_index_i;
      val_d = new_value_i;
      ptr_d = last_c;
      case (req_type_i)
        alis_pkg::REQ_READ:  zero_d = !used;
        alis_pkg::REQ_WRITE: zero_d = 1'b1;
        alis_pkg::REQ_INSERT: begin
          if (val_nz && !full) fill_d = fill_q + alis_pkg::CntW'(1);
        end
        default: zero_d = zero_q;
      endcase
    end else if (state_q == alis_pkg::ST_SHIFT && shift_more) begin
      ptr_d = ptr_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= alis_pkg::ST_IDLE;
      fill_q  <= '0;
      zero_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      zero_q  <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    idx_q <= idx_d;
    val_q <= val_d;
  end

endmodule

// ===== src/array_list_insert_shift_unit.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_shift_unit
// Ordered list of positive values in a single RAM with insert-and-shift.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_type_i, slot_index_i, new_value_i) is taken at a
//   rising edge with start high and busy low. Read returns the slot or 0 if
//   empty; overwrite replaces an occupied slot and answers 0 if the slot is
//   empty; insert shifts the slot and all later ones up, or appends at an
//   empty index. A word with value 0 (overwrite or insert) or an unknown
//   code is dropped without an answer.
//   Answers appear on read_value_o with valid_o high for the one cycle that
//   follows the accept edge, and are taken at the edge that ends it, after
//   one RAM read. The receiver has no back-pressure; answers must be taken
//   as they come.
//   Sequencing: a read or a rejected overwrite holds busy high in its answer
//   state; an overwrite or append writes without going busy; an insert at
//   occupied index k below min(n, DEPTH-1), with n occupied slots, fetches
//   slot min(n, DEPTH-1) - 1 and then walks down, the single RAM write port
//   moving one element per cycle, before it writes the new value at k; an
//   insert at the last slot of a full store replaces it without going busy.
//   Reset clears only state and fill count; slots past the fill count read as
//   empty, so the RAM needs no clearing pass and the unit is ready at once.
// ----------------------------------------------------------------------------
module array_list_insert_shift_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [alis_pkg::ReqW-1:0] req_type_i,
  input  logic [alis_pkg::IdxW-1:0] slot_index_i,
  input  logic [alis_pkg::ValW-1:0] new_value_i,
  output logic                      valid_o,
  output logic [alis_pkg::ValW-1:0] read_value_o
);

  alis_pkg::mem_req_t        mem_req;
  logic [alis_pkg::ValW-1:0] rdata;

  // sequencer
  alis_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .req_type_i   (req_type_i),
    .slot_index_i (slot_index_i),
    .new_value_i  (new_value_i),
    .rdata_i      (rdata),
    .mem_req_o    (mem_req),
    .busy         (busy),
    .valid_o      (valid_o),
    .read_value_o (read_value_o)
  );

  // element store
  alis_ram #(
    .Width (alis_pkg::ValW),
    .Depth (alis_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  // every answer comes in the cycle after an accepted word
  a_answer_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy))
    else $error("answer without an accepted word one cycle earlier");

  // answers are single-cycle pulses
  a_answer_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("answer held for more than one cycle");

  // during a shift the write never hits the slot being fetched
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && mem_req.we) |-> (mem_req.waddr != mem_req.raddr))
    else $error("RAM write and read collide during a multi-cycle request");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array list insert/shift unit.
// Request words go in through the start/busy handshake, and every answer on
// valid_o is compared with a shadow list that the bench keeps in step. A short
// table covers reset state, extremes and the dropped cases. Random traffic then
// grows the list with reads, overwrites, inserts with shift and appends. The
// sender runs in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned GROW_WORDS  = 490;
  localparam int unsigned MAX_GAP     = 20;
  localparam int unsigned DIR_ROWS    = 26;
  localparam logic [alis_pkg::ReqW-1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [alis_pkg::ValW-1:0] VAL_MAX     = '1;
  // Worst case per word: a full-length shift plus the longest gap, taken 4x
  localparam longint unsigned CYCLE_LIMIT =
    64'd4 * (DIR_ROWS + 2 * GROW_WORDS + alis_pkg::DEPTH) *
    (alis_pkg::DEPTH + 2 + MAX_GAP);

  // One directed row; answer is used only when check is set
  typedef struct packed {
    logic [alis_pkg::ReqW-1:0] req;
    logic [alis_pkg::IdxW-1:0] idx;
    logic [alis_pkg::ValW-1:0] val;
    logic                      check;
    logic [alis_pkg::ValW-1:0] answer;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [alis_pkg::ReqW-1:0] req_type_i;
  logic [alis_pkg::IdxW-1:0] slot_index_i;
  logic [alis_pkg::ValW-1:0] new_value_i;
  logic                      valid_o;
  logic [alis_pkg::ValW-1:0] read_value_o;

  // Directed answer travels with the word it belongs to
  logic                      dir_check_en;
  logic [alis_pkg::ValW-1:0] dir_answer;

  logic [alis_pkg::ValW-1:0] shadow_slots [alis_pkg::DEPTH];
  int                        shadow_fill;
  logic [alis_pkg::ValW-1:0] pending_reads [$];
  logic [alis_pkg::ValW-1:0] model_answer;
  logic [alis_pkg::ValW-1:0] got_answer;
  int                        err_count   = 0;
  int                        burst_left  = 0;
  longint unsigned           cycle_count = 0;

  // Empty store at reset: each answer follows from the rows before it
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{alis_pkg::REQ_READ,   10'd0,    31'd0,        1'b1, 31'd0},
    '{alis_pkg::REQ_READ,   10'd1023, 31'd0,        1'b1, 31'd0},
    '{alis_pkg::REQ_WRITE,  10'd0,    31'd5,        1'b1, 31'd0},
    '{alis_pkg::REQ_WRITE,  10'd1023, VAL_MAX,      1'b1, 31'd0},
    '{alis_pkg::REQ_INSERT, 10'd0,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd0,    31'd0,        1'b1, 31'd0},
    '{alis_pkg::REQ_INSERT, 10'd500,  VAL_MAX,      1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd0,    31'd0,        1'b1, VAL_MAX},
    '{alis_pkg::REQ_INSERT, 10'd0,    31'd1,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd0,    31'd0,        1'b1, 31'd1},
    '{alis_pkg::REQ_READ,   10'd1,    31'd0,        1'b1, VAL_MAX},
    '{alis_pkg::REQ_INSERT, 10'd1,    31'h2AAAAAAA, 1'b0, 31'd0},
    '{alis_pkg::REQ_INSERT, 10'd1023, 31'h55555555, 1'b0, 31'd0},
    '{alis_pkg::REQ_WRITE,  10'd2,    31'h12345678, 1'b0, 31'd0},
    '{alis_pkg::REQ_WRITE,  10'd2,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_WRITE,  10'd4,    31'd9,        1'b1, 31'd0},
    '{REQ_UNKNOWN,          10'd0,    31'd77,       1'b0, 31'd0},
    '{REQ_UNKNOWN,          10'd1023, VAL_MAX,      1'b0, 31'd0},
    '{alis_pkg::REQ_INSERT, 10'd3,    31'd3,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd0,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd1,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd2,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd3,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd4,    31'd0,        1'b0, 31'd0},
    '{alis_pkg::REQ_READ,   10'd5,    31'd0,        1'b1, 31'd0},
    '{alis_pkg::REQ_READ,   10'd1023, 31'd0,        1'b1, 31'd0}
  };

  array_list_insert_shift_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .slot_index_i (slot_index_i),
    .new_value_i  (new_value_i),
    .valid_o      (valid_o),
    .read_value_o (read_value_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Shadow list: applies one word, returns 1 when the unit must answer
  function automatic bit apply_request(input logic [alis_pkg::ReqW-1:0] req,
                                       input logic [alis_pkg::IdxW-1:0] idx,
                                       input logic [alis_pkg::ValW-1:0] val,
                                       output logic [alis_pkg::ValW-1:0] answer);
    int pos;
    int top;
    bit used;
    pos    = int'(idx);
    used   = (pos < shadow_fill) && (pos < int'(alis_pkg::DEPTH));
    answer = '0;
    case (req)
      alis_pkg::REQ_READ: begin
        if (used) answer = shadow_slots[pos];
        return 1'b1;
      end
      alis_pkg::REQ_WRITE: begin
        if (val == '0) return 1'b0;
        if (!used) return 1'b1;
        shadow_slots[pos] = val;
        return 1'b0;
      end
      alis_pkg::REQ_INSERT: begin
        if (val == '0) return 1'b0;
        // empty index: append, unless the store is full
        if (!used) begin
          if (shadow_fill < int'(alis_pkg::DEPTH)) begin
            shadow_slots[shadow_fill] = val;
            shadow_fill++;
          end
          return 1'b0;
        end
        // full store drops the last element
        top = (shadow_fill < int'(alis_pkg::DEPTH)) ? shadow_fill :
              int'(alis_pkg::DEPTH) - 1;
        for (int k = top; k > pos; k--) shadow_slots[k] = shadow_slots[k - 1];
        shadow_slots[pos] = val;
        if (shadow_fill < int'(alis_pkg::DEPTH)) shadow_fill++;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Values: mostly wide random, with zero, small and all-ones mixed in
  function automatic logic [alis_pkg::ValW-1:0] pick_value();
    int p;
    p = $urandom_range(99, 0);
    if (p < 5) return '0;
    if (p < 15) return alis_pkg::ValW'($urandom_range(16, 1));
    if (p < 20) return VAL_MAX;
    return alis_pkg::ValW'($urandom());
  endfunction

  function automatic logic [alis_pkg::IdxW-1:0] pick_used_index();
    if (shadow_fill > 0) return alis_pkg::IdxW'($urandom_range(shadow_fill - 1, 0));
    return alis_pkg::IdxW'($urandom_range(alis_pkg::DEPTH - 1, 0));
  endfunction

  // Random word; ignored is set for words that the unit just drops
  task automatic next_word(output logic [alis_pkg::ReqW-1:0] req,
                           output logic [alis_pkg::IdxW-1:0] idx,
                           output logic [alis_pkg::ValW-1:0] val,
                           output bit ignored);
    int p;
    p   = $urandom_range(99, 0);
    val = pick_value();
    if (p < 35) req = alis_pkg::REQ_READ;
    else if (p < 55) req = alis_pkg::REQ_WRITE;
    else if (p < 92) req = alis_pkg::REQ_INSERT;
    else req = REQ_UNKNOWN;
    if (req == alis_pkg::REQ_INSERT && shadow_fill < int'(alis_pkg::DEPTH) &&
        $urandom_range(1, 0) == 0) begin
      idx = alis_pkg::IdxW'($urandom_range(alis_pkg::DEPTH - 1, shadow_fill));
    end else if ($urandom_range(9, 0) < 7) begin
      idx = pick_used_index();
    end else begin
      idx = alis_pkg::IdxW'($urandom_range(alis_pkg::DEPTH - 1, 0));
    end
    ignored = (req == REQ_UNKNOWN) || (req != alis_pkg::REQ_READ && val == '0);
  endtask

  // Drive one word at the falling edge and hold it until taken
  task automatic send_word(input logic [alis_pkg::ReqW-1:0] req,
                           input logic [alis_pkg::IdxW-1:0] idx,
                           input logic [alis_pkg::ValW-1:0] val, input logic check,
                           input logic [alis_pkg::ValW-1:0] answer);
    start        <= 1'b1;
    req_type_i   <= req;
    slot_index_i <= idx;
    new_value_i  <= val;
    dir_check_en <= check;
    dir_answer   <= answer;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Burst pacing: after each burst, usually a random gap with start low
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(64, 16) : $urandom_range(12, 1);
      if ($urandom_range(3, 0) != 0) begin
        gap = $urandom_range(MAX_GAP, 1);
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Answer check and prediction, both on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (pending_reads.size() == 0) begin
          $error("read_value: expected none, got %0h", read_value_o);
          err_count++;
        end else begin
          got_answer = pending_reads.pop_front();
          if (read_value_o !== got_answer) begin
            $error("read_value: expected %0h, got %0h", got_answer, read_value_o);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        if (apply_request(req_type_i, slot_index_i, new_value_i, model_answer))
          pending_reads.push_back(dir_check_en ? dir_answer : model_answer);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic [alis_pkg::ReqW-1:0] req;
    logic [alis_pkg::IdxW-1:0] idx;
    logic [alis_pkg::ValW-1:0] val;
    bit                        ignored;
    int                        counted;
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = '0;
    slot_index_i = '0;
    new_value_i  = '0;
    dir_check_en = 1'b0;
    dir_answer   = '0;
    shadow_fill  = 0;
    foreach (shadow_slots[n]) shadow_slots[n] = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    foreach (dir_rows[n]) begin
      send_word(dir_rows[n].req, dir_rows[n].idx, dir_rows[n].val,
                dir_rows[n].check, dir_rows[n].answer);
      pace();
    end

    // Random traffic on a growing list
    counted = 0;
    while (counted < GROW_WORDS) begin
      next_word(req, idx, val, ignored);
      send_word(req, idx, val, 1'b0, '0);
      if (!ignored) counted++;
      pace();
    end
    start <= 1'b0;

    // Drain, then let a last shift run out
    while (pending_reads.size() != 0) @(posedge clk_i);
    repeat (alis_pkg::DEPTH + 8) @(posedge clk_i);
    if (pending_reads.size() != 0) begin
      $error("read_value: %0d answers never came", pending_reads.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
